// ===== sv/wbps_pkg.sv =====
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants of the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

   // Window depth in bytes (largest signature), range 1 to 16
   localparam int PATTERN_MAX = 16;
   // Width of the segment byte position, range 8 to 48
   localparam int OFFSET_BITS = 32;

   localparam int LEN_W      = $clog2(PATTERN_MAX + 1);
   localparam int IDX_W      = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int CMP_W      = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

   // Fixed register and field widths
   localparam int DATA_W     = 64;
   localparam int CARE_W     = 16;
   localparam int LEN_CFG_W  = 5;
   localparam int START_W    = 32;
   localparam int COUNT_W    = 16;
   localparam int ADDR_W     = 64;
   localparam int OFS_OUT_W  = 32;
   localparam int CSR_IDX_W  = 3;

   // Queue between front and back (power of two)
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LOW    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_HIGH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CARE_MASK      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_START_OFFSET   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_MATCHES    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDRESS   = 3'd6;

   typedef enum logic {
      REC_MATCH = 1'b0,
      REC_END   = 1'b1
   } record_kind_type;

   typedef struct packed {
      logic [DATA_W-1:0]    pattern_low;
      logic [DATA_W-1:0]    pattern_high;
      logic [CARE_W-1:0]    care_mask;
      logic [LEN_CFG_W-1:0] pattern_length;
      logic [START_W-1:0]   start_offset;
      logic [COUNT_W-1:0]   max_matches;
      logic [ADDR_W-1:0]    base_address;
   } cfg_type;

   // Outcome of one byte: a match record, an end record, or both
   typedef struct packed {
      logic                   has_match;
      logic                   has_end;
      logic [OFFSET_BITS-1:0] start_pos;
      logic [COUNT_W-1:0]     count;
   } entry_type;

endpackage

// ===== sv/wbps_front.sv =====
// ----------------------------------------------------------------------------
// wbps_front
// Byte window, masked signature compare and match bookkeeping; one byte
// per cycle while accept is high, pushing an entry for each record byte.
// ----------------------------------------------------------------------------
module wbps_front (
   input  logic                          clock,
   input  logic                          reset,
   input  wbps_pkg::cfg_type             cfg,
   input  logic                          accept,
   input  logic [7:0]                    data_byte,
   input  logic                          last_byte,
   output logic                          push,
   output wbps_pkg::entry_type           push_entry
);

   logic [7:0]                           win_ff [wbps_pkg::PATTERN_MAX];
   logic [7:0]                           win_in [wbps_pkg::PATTERN_MAX];
   logic [wbps_pkg::OFFSET_BITS-1:0]     pos_ff, pos_in;
   logic [wbps_pkg::COUNT_W-1:0]         found_ff, found_in;
   logic                                 limit_ff, limit_in;

   logic [wbps_pkg::LEN_W-1:0]           len_used;
   logic [wbps_pkg::LEN_W-1:0]           rev_idx [wbps_pkg::PATTERN_MAX];
   logic [wbps_pkg::PATTERN_MAX-1:0]     byte_hit;
   logic [2*wbps_pkg::DATA_W-1:0]        sig_all;
   logic [wbps_pkg::OFFSET_BITS-1:0]     filled;
   logic [wbps_pkg::OFFSET_BITS-1:0]     start_pos;
   logic [wbps_pkg::CMP_W-1:0]           start_ext, limit_ext;
   logic                                 advance, full_enough, room, emit;

   // Clamp the signature length to 1..PATTERN_MAX
   always_comb begin
      if (cfg.pattern_length == '0) begin
         len_used = wbps_pkg::LEN_W'(1);
      end else if (cfg.pattern_length >
                   wbps_pkg::LEN_CFG_W'(wbps_pkg::PATTERN_MAX)) begin
         len_used = wbps_pkg::LEN_W'(wbps_pkg::PATTERN_MAX);
      end else begin
         len_used = wbps_pkg::LEN_W'(cfg.pattern_length);
      end
   end

   // Shift in the new byte, newest at index 0
   always_comb begin
      win_in[0] = data_byte;
      for (int i = 1; i < wbps_pkg::PATTERN_MAX; i++) begin
         win_in[i] = win_ff[i-1];
      end
   end

   // Compare every signature byte against its window byte in parallel
   assign sig_all = {cfg.pattern_high, cfg.pattern_low};

   always_comb begin
      for (int i = 0; i < wbps_pkg::PATTERN_MAX; i++) begin
         rev_idx[i]  = len_used - wbps_pkg::LEN_W'(i) - wbps_pkg::LEN_W'(1);
         byte_hit[i] = (wbps_pkg::LEN_W'(i) >= len_used) || !cfg.care_mask[i] ||
                       (win_in[rev_idx[i][wbps_pkg::IDX_W-1:0]] == sig_all[8*i +: 8]);
      end
   end

   // Position, start offset and limit checks
   assign advance     = (pos_ff != '1);
   assign filled      = pos_ff + wbps_pkg::OFFSET_BITS'(1);
   assign full_enough = (filled >= wbps_pkg::OFFSET_BITS'(len_used));
   assign start_pos   = filled - wbps_pkg::OFFSET_BITS'(len_used);
   assign start_ext   = wbps_pkg::CMP_W'(start_pos);
   assign limit_ext   = wbps_pkg::CMP_W'(cfg.start_offset);
   assign room        = !limit_ff &&
                        ((cfg.max_matches == '0) || (found_ff < cfg.max_matches));
   assign emit        = advance && full_enough && (&byte_hit) &&
                        (start_ext >= limit_ext) && room;

   // Next scan state
   always_comb begin
      pos_in   = pos_ff;
      found_in = found_ff;
      limit_in = limit_ff;
      if (advance) begin
         pos_in = filled;
      end
      if (emit) begin
         if (found_ff != '1) begin
            found_in = found_ff + wbps_pkg::COUNT_W'(1);
         end
         if ((cfg.max_matches != '0) && (found_in >= cfg.max_matches)) begin
            limit_in = 1'b1;
         end
      end
   end

   // Entry for the queue
   assign push                 = accept && (emit || last_byte);
   assign push_entry.has_match = emit;
   assign push_entry.has_end   = last_byte;
   assign push_entry.start_pos = start_pos;
   assign push_entry.count     = found_in;

   // Update scan state; clear it after the last byte of a segment
   always_ff @(posedge clock) begin
      if (reset || (accept && last_byte)) begin
         for (int i = 0; i < wbps_pkg::PATTERN_MAX; i++) begin
            win_ff[i] <= '0;
         end
         pos_ff   <= '0;
         found_ff <= '0;
         limit_ff <= 1'b0;
      end else if (accept) begin
         win_ff   <= win_in;
         pos_ff   <= pos_in;
         found_ff <= found_in;
         limit_ff <= limit_in;
      end
   end

endmodule

// ===== sv/wbps_queue.sv =====
// ----------------------------------------------------------------------------
// wbps_queue
// Short register queue of pending entries between front and back.
// ----------------------------------------------------------------------------
module wbps_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  wbps_pkg::entry_type  push_entry,
   input  logic                 pop,
   output wbps_pkg::entry_type  head,
   output logic                 not_empty,
   output logic                 full
);

   wbps_pkg::entry_type              slot_ff [wbps_pkg::QUEUE_DEPTH];
   logic [wbps_pkg::QPTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [wbps_pkg::QFILL_W-1:0]     fill_ff;

   assign head      = slot_ff[rd_ptr_ff];
   assign not_empty = (fill_ff != '0);
   assign full      = (fill_ff == wbps_pkg::QFILL_W'(wbps_pkg::QUEUE_DEPTH));

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + wbps_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + wbps_pkg::QPTR_W'(1);
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + wbps_pkg::QFILL_W'(1);
         end else if (pop && !push) begin
            fill_ff <= fill_ff - wbps_pkg::QFILL_W'(1);
         end
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== sv/wbps_back.sv =====
// ----------------------------------------------------------------------------
// wbps_back
// Turns queue entries into output words: a match word, an end word, or a
// match word followed by an end word; forms the match address.
// ----------------------------------------------------------------------------
module wbps_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [wbps_pkg::ADDR_W-1:0]       base_address,
   input  wbps_pkg::entry_type               head,
   input  logic                              not_empty,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_record_kind,
   output logic [wbps_pkg::OFS_OUT_W-1:0]    rsp_match_offset,
   output logic [wbps_pkg::ADDR_W-1:0]       rsp_match_address,
   output logic [wbps_pkg::COUNT_W-1:0]      rsp_match_count,
   output logic                              rsp_last_of_run
);

   logic                                 out_valid_ff, out_valid_in;
   logic                                 pend_end_ff, pend_end_in;
   wbps_pkg::record_kind_type            kind_ff, kind_in;
   logic [wbps_pkg::OFS_OUT_W-1:0]       offset_ff, offset_in;
   logic [wbps_pkg::ADDR_W-1:0]          address_ff, address_in;
   logic [wbps_pkg::COUNT_W-1:0]         count_ff, count_in;
   logic                                 last_ff, last_in;
   logic [wbps_pkg::CMP_W-1:0]           head_pos_ext;
   logic                                 slot_free;

   assign slot_free    = !out_valid_ff || rsp_ready;
   assign head_pos_ext = wbps_pkg::CMP_W'(head.start_pos);

   // Load the output word from the pending end or the queue head
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      pend_end_in  = pend_end_ff;
      kind_in      = kind_ff;
      offset_in    = offset_ff;
      address_in   = address_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      pop          = 1'b0;
      if (slot_free) begin
         if (pend_end_ff) begin
            out_valid_in = 1'b1;
            pend_end_in  = 1'b0;
            kind_in      = wbps_pkg::REC_END;
            offset_in    = '0;
            address_in   = '0;
            last_in      = 1'b1;
         end else if (not_empty) begin
            pop          = 1'b1;
            out_valid_in = 1'b1;
            count_in     = head.count;
            if (head.has_match) begin
               kind_in     = wbps_pkg::REC_MATCH;
               offset_in   = head_pos_ext[wbps_pkg::OFS_OUT_W-1:0];
               address_in  = base_address + wbps_pkg::ADDR_W'(head.start_pos);
               last_in     = !head.has_end;
               pend_end_in = head.has_end;
            end else begin
               kind_in    = wbps_pkg::REC_END;
               offset_in  = '0;
               address_in = '0;
               last_in    = 1'b1;
            end
         end
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend_end_ff  <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         pend_end_ff  <= pend_end_in;
      end
   end

   // Hold the output word
   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      offset_ff  <= offset_in;
      address_ff <= address_in;
      count_ff   <= count_in;
      last_ff    <= last_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_record_kind   = kind_ff;
   assign rsp_match_offset  = offset_ff;
   assign rsp_match_address = address_ff;
   assign rsp_match_count   = count_ff;
   assign rsp_last_of_run   = last_ff;

   // A pending end word always follows a match word still on the port
   a_pend_needs_word: assert property (@(posedge clock) disable iff (reset)
      pend_end_ff |-> out_valid_ff)
      else $error("pending end word without a match word on the port");

   // An end word always closes its run
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (kind_ff == wbps_pkg::REC_END)) |-> rsp_last_of_run)
      else $error("end word without last_of_run");

   // A match word counts itself
   a_match_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (kind_ff == wbps_pkg::REC_MATCH)) |-> (rsp_match_count != '0))
      else $error("match word with zero count");

   // The end word follows its match word directly
   a_end_follows: assert property (@(posedge clock) disable iff (reset)
      (pend_end_ff && rsp_ready) |=> (rsp_valid && (kind_ff == wbps_pkg::REC_END)))
      else $error("end word did not follow its match word");

endmodule

// ===== sv/wildcard_byte_pattern_scanner.sv =====
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner
// Streams segment bytes through a window and reports wildcard signature hits.
// ----------------------------------------------------------------------------
// The scanner takes one segment byte per cycle on req_ while req_ready is
// high, compares the last pattern_length bytes against the signature (clear
// care bits are wildcards) and returns words on rsp_: a match word with
// offset, address and running count, and on the last byte an end word with
// the count, after which the scan state starts over. A byte is compared in
// the cycle it is taken; its entry waits in a two-entry queue, then goes to
// the output register. The back stage puts out one word per cycle while
// rsp_ready is high; a byte ending both a match and the segment yields two
// words. req_ready drops only while the queue is full. The user must write
// registers through csr_ while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [wbps_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [wbps_pkg::DATA_W-1:0]       csr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_data_byte,
   input  logic                              req_last_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_record_kind,
   output logic [wbps_pkg::OFS_OUT_W-1:0]    rsp_match_offset,
   output logic [wbps_pkg::ADDR_W-1:0]       rsp_match_address,
   output logic [wbps_pkg::COUNT_W-1:0]      rsp_match_count,
   output logic                              rsp_last_of_run
);

   wbps_pkg::cfg_type    cfg_ff;
   wbps_pkg::entry_type  push_entry, head;
   logic                 push, pop, not_empty, full, accept;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_low    <= '0;
         cfg_ff.pattern_high   <= '0;
         cfg_ff.care_mask      <= '1;
         cfg_ff.pattern_length <= wbps_pkg::LEN_CFG_W'(1);
         cfg_ff.start_offset   <= '0;
         cfg_ff.max_matches    <= '0;
         cfg_ff.base_address   <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            wbps_pkg::CSR_PATTERN_LOW: begin
               cfg_ff.pattern_low <= csr_data;
            end
            wbps_pkg::CSR_PATTERN_HIGH: begin
               cfg_ff.pattern_high <= csr_data;
            end
            wbps_pkg::CSR_CARE_MASK: begin
               cfg_ff.care_mask <= csr_data[wbps_pkg::CARE_W-1:0];
            end
            wbps_pkg::CSR_PATTERN_LENGTH: begin
               cfg_ff.pattern_length <= csr_data[wbps_pkg::LEN_CFG_W-1:0];
            end
            wbps_pkg::CSR_START_OFFSET: begin
               cfg_ff.start_offset <= csr_data[wbps_pkg::START_W-1:0];
            end
            wbps_pkg::CSR_MAX_MATCHES: begin
               cfg_ff.max_matches <= csr_data[wbps_pkg::COUNT_W-1:0];
            end
            wbps_pkg::CSR_BASE_ADDRESS: begin
               cfg_ff.base_address <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // Take a byte whenever the queue has room
   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   wbps_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .last_byte  (req_last_byte),
      .push       (push),
      .push_entry (push_entry)
   );

   wbps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .not_empty  (not_empty),
      .full       (full)
   );

   wbps_back u_back (
      .clock             (clock),
      .reset             (reset),
      .base_address      (cfg_ff.base_address),
      .head              (head),
      .not_empty         (not_empty),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_record_kind   (rsp_record_kind),
      .rsp_match_offset  (rsp_match_offset),
      .rsp_match_address (rsp_match_address),
      .rsp_match_count   (rsp_match_count),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
// Segment bytes go in on req_ and result words come back on rsp_. Both sides
// idle at random. A scan tracker keeps its own copy of the window, position,
// match count and limit flag, together with the register settings. For every
// byte that is taken it predicts the match and end words, and it checks each
// returned word against the oldest prediction, field by field. A short
// directed part comes first: reset settings, a full sixteen byte signature, a
// pattern longer than its segment, out of range lengths, a start offset and
// a limit lowered in the middle of a segment. After that come random phases,
// each with new register settings and segments that mostly carry planted
// signatures. A watchdog ends the run if nothing moves.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import wbps_pkg::*;

   localparam int QUIET_LIMIT    = 2000;
   localparam int LONG_HOLD      = 300;
   localparam int RANDOM_ITEMS   = 1500;
   localparam int MAX_REPORTS    = 40;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   typedef struct {
      record_kind_type     kind;
      logic [OFS_OUT_W-1:0] offset;
      logic [ADDR_W-1:0]    address;
      logic [COUNT_W-1:0]   count;
      logic                 last_of_run;
   } scan_word_type;

   // Tracks the scan state and holds the words still owed by the block
   class scan_tracker;
      cfg_type                cfg;
      logic [7:0]             window [PATTERN_MAX];
      logic [OFFSET_BITS-1:0] position;
      logic [COUNT_W-1:0]     found;
      bit                     limit_hit;
      scan_word_type          owed_words [$];
      int                     errors;

      function new();
         cfg = '0;
         cfg.care_mask = '1;
         cfg.pattern_length = LEN_CFG_W'(1);
         errors = 0;
         restart();
      endfunction

      function void restart();
         foreach (window[i]) window[i] = 8'h00;
         position = '0;
         found = '0;
         limit_hit = 1'b0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
         case (idx)
            CSR_PATTERN_LOW:    cfg.pattern_low    = value;
            CSR_PATTERN_HIGH:   cfg.pattern_high   = value;
            CSR_CARE_MASK:      cfg.care_mask      = value[CARE_W-1:0];
            CSR_PATTERN_LENGTH: cfg.pattern_length = value[LEN_CFG_W-1:0];
            CSR_START_OFFSET:   cfg.start_offset   = value[START_W-1:0];
            CSR_MAX_MATCHES:    cfg.max_matches    = value[COUNT_W-1:0];
            CSR_BASE_ADDRESS:   cfg.base_address   = value[ADDR_W-1:0];
            default: ;
         endcase
      endfunction

      // Zero counts as one, anything past the window depth is clipped
      function int used_len();
         if (cfg.pattern_length == 0) return 1;
         if (cfg.pattern_length > PATTERN_MAX) return PATTERN_MAX;
         return int'(cfg.pattern_length);
      endfunction

      // Shift one byte in and queue the words it must produce
      function void take_byte(logic [7:0] data, logic last);
         int                     len;
         logic [127:0]           sig;
         logic [OFFSET_BITS-1:0] start_pos;
         bit                     hit;
         bit                     room;
         scan_word_type          w;
         len = used_len();
         sig = {cfg.pattern_high, cfg.pattern_low};
         for (int i = PATTERN_MAX - 1; i > 0; i--) window[i] = window[i-1];
         window[0] = data;
         // a byte at the saturated position never completes a match
         if (position != '1) begin
            position++;
            if (position >= len) begin
               hit = 1'b1;
               for (int i = 0; i < len; i++) begin
                  if (cfg.care_mask[i] && window[len-1-i] != sig[8*i +: 8]) hit = 1'b0;
               end
               start_pos = OFFSET_BITS'(position - len);
               room = !limit_hit && (cfg.max_matches == 0 || found < cfg.max_matches);
               if (hit && start_pos >= cfg.start_offset && room) begin
                  if (found != '1) found++;
                  if (cfg.max_matches != 0 && found >= cfg.max_matches) limit_hit = 1'b1;
                  w.kind        = REC_MATCH;
                  w.offset      = start_pos;
                  w.address     = cfg.base_address + ADDR_W'(start_pos);
                  w.count       = found;
                  w.last_of_run = !last;
                  owed_words.insert(owed_words.size(), w);
               end
            end
         end
         // end of segment: summary word, then start over
         if (last) begin
            w.kind        = REC_END;
            w.offset      = '0;
            w.address     = '0;
            w.count       = found;
            w.last_of_run = 1'b1;
            owed_words.insert(owed_words.size(), w);
            restart();
         end
      endfunction

      function void compare(string field, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
         if (want !== got) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         end
      endfunction

      function void check_word(scan_word_type got);
         scan_word_type want;
         if (owed_words.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: word with none owed, expected none, actual kind %0d offset %0h count %0d",
                        $time, got.kind, got.offset, got.count);
            return;
         end
         want = owed_words.pop_front();
         compare("record_kind", want.kind, got.kind);
         compare("match_offset", want.offset, got.offset);
         compare("match_address", want.address, got.address);
         compare("match_count", want.count, got.count);
         compare("last_of_run", want.last_of_run, got.last_of_run);
      endfunction

      function int pending();
         return owed_words.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [DATA_W-1:0]     csr_data;
   logic                  req_valid;
   logic                  req_ready;
   logic [7:0]            req_data_byte;
   logic                  req_last_byte;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_record_kind;
   logic [OFS_OUT_W-1:0]  rsp_match_offset;
   logic [ADDR_W-1:0]     rsp_match_address;
   logic [COUNT_W-1:0]    rsp_match_count;
   logic                  rsp_last_of_run;

   scan_tracker tracker;
   int          send_gap_max = 16;
   int          recv_gap_max = 16;
   int          random_items = 0;
   bit          hold_request = 1'b0;
   bit          started      = 1'b0;

   wildcard_byte_pattern_scanner i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_record_kind   (rsp_record_kind),
      .rsp_match_offset  (rsp_match_offset),
      .rsp_match_address (rsp_match_address),
      .rsp_match_count   (rsp_match_count),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Offer one byte after a random gap and hold it until taken
   task automatic send_byte(logic [7:0] data, logic last);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      req_last_byte <= last;
      do @(posedge clock); while (req_ready !== 1'b1);
      tracker.take_byte(data, last);
   endtask

   // Drop valid, wait for every owed word, then let the pipeline empty
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      tracker.write_reg(idx, value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // Set unused upper data bits now and then; the block must ignore them
   function automatic logic [DATA_W-1:0] with_noise(logic [DATA_W-1:0] value, int width);
      if ($urandom_range(0, 3) == 0) return value | ({$urandom, $urandom} << width);
      return value;
   endfunction

   task automatic load_config(int len, logic [DATA_W-1:0] low, logic [DATA_W-1:0] high,
                              logic [CARE_W-1:0] care, logic [START_W-1:0] start,
                              logic [COUNT_W-1:0] max_count, logic [ADDR_W-1:0] base);
      write_reg(CSR_PATTERN_LOW, low);
      write_reg(CSR_PATTERN_HIGH, high);
      write_reg(CSR_CARE_MASK, with_noise(DATA_W'(care), CARE_W));
      write_reg(CSR_PATTERN_LENGTH, with_noise(DATA_W'(len), LEN_CFG_W));
      write_reg(CSR_START_OFFSET, with_noise(DATA_W'(start), START_W));
      write_reg(CSR_MAX_MATCHES, with_noise(DATA_W'(max_count), COUNT_W));
      write_reg(CSR_BASE_ADDRESS, base);
   endtask

   // Short patterns mostly, so that planted and chance matches both occur
   task automatic random_config();
      int                 len;
      logic [CARE_W-1:0]  care;
      logic [START_W-1:0] start;
      logic [COUNT_W-1:0] max_count;
      logic [ADDR_W-1:0]  base;
      case ($urandom_range(0, 15))
         0, 1:    len = PATTERN_MAX;
         2:       len = $urandom_range(0, 31);
         default: len = $urandom_range(1, 4);
      endcase
      case ($urandom_range(0, 7))
         0, 1:    care = '1;
         2:       care = '0;
         default: care = CARE_W'($urandom);
      endcase
      case ($urandom_range(0, 15))
         0:       start = $urandom;
         1:       start = '1;
         default: start = $urandom_range(0, 8);
      endcase
      case ($urandom_range(0, 7))
         0, 1, 2, 3: max_count = '0;
         4, 5:       max_count = COUNT_W'($urandom_range(1, 4));
         6:          max_count = '1;
         default:    max_count = COUNT_W'($urandom);
      endcase
      if ($urandom_range(0, 3) == 0) base = '1 - ADDR_W'($urandom_range(0, 64));
      else base = {$urandom, $urandom};
      load_config(len, {$urandom, $urandom}, {$urandom, $urandom}, care, start, max_count, base);
   endtask

   // Build one segment: planted signatures with random wildcard bytes,
   // stray signature bytes and noise; some segments are left open
   task automatic send_segment();
      logic [7:0]   seg [$];
      logic [127:0] sig;
      int           ulen;
      int           seg_len;
      int           pick;
      int           sel;
      bit           noise;
      bit           terminate;
      ulen = tracker.used_len();
      sig  = {tracker.cfg.pattern_high, tracker.cfg.pattern_low};
      case ($urandom_range(0, 7))
         0:       seg_len = $urandom_range(40, 80);
         1:       seg_len = $urandom_range(1, ulen);
         default: seg_len = $urandom_range(1, 24);
      endcase
      noise     = ($urandom_range(0, 4) == 0);
      terminate = ($urandom_range(0, 7) != 0);
      while (seg.size() < seg_len) begin
         pick = noise ? 2 : $urandom_range(0, 3);
         case (pick)
            0, 1: begin
               for (int i = 0; i < ulen; i++)
                  seg.insert(seg.size(),
                             tracker.cfg.care_mask[i] ? sig[8*i +: 8] : 8'($urandom));
            end
            2: seg.insert(seg.size(), 8'($urandom));
            default: begin
               sel = $urandom_range(0, ulen - 1);
               seg.insert(seg.size(), sig[8*sel +: 8]);
            end
         endcase
      end
      while (seg.size() > seg_len) void'(seg.pop_back());
      foreach (seg[k]) begin
         send_byte(seg[k], terminate && k == seg.size() - 1);
         random_items++;
      end
   endtask

   // Receive words after random stalls; one long hold on request
   initial begin : take_words
      int            stall;
      scan_word_type got;
      rsp_ready = 1'b0;
      wait (started);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall = LONG_HOLD;
         end else begin
            stall = $urandom_range(0, recv_gap_max);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         got.kind        = record_kind_type'(rsp_record_kind);
         got.offset      = rsp_match_offset;
         got.address     = rsp_match_address;
         got.count       = rsp_match_count;
         got.last_of_run = rsp_last_of_run;
         tracker.check_word(got);
      end
   end

   // End the run once nothing has been taken or returned for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      wait (started);
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("testbench: FAIL");
      $finish;
   end

   initial begin : run_scan
      logic [127:0] sig;
      int           phase;
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      req_valid     = 1'b0;
      req_data_byte = '0;
      req_last_byte = 1'b0;
      tracker = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      started = 1'b1;

      // reset settings: one byte signature 00, every byte cared for
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      settle();

      // index with no register behind it
      write_reg(CSR_UNUSED, '1);

      // full window signature, all byte extremes, base at the top
      load_config(PATTERN_MAX, 64'h807F_55AA_01FE_FF00, 64'h0FF0_C33C_9669_A55A,
                  '1, '0, '0, '1);
      sig = {tracker.cfg.pattern_high, tracker.cfg.pattern_low};
      for (int i = 0; i < PATTERN_MAX; i++) send_byte(sig[8*i +: 8], i == PATTERN_MAX - 1);

      // segment shorter than the pattern: end word only
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      settle();

      // length zero acts as one
      write_reg(CSR_PATTERN_LENGTH, with_noise(DATA_W'(0), LEN_CFG_W));
      send_byte(8'h00, 1'b1);
      settle();

      // length past the window is clipped to the window
      write_reg(CSR_PATTERN_LENGTH, 64'd31);
      send_byte(8'h00, 1'b1);
      settle();

      // all wildcards from offset one, then lower the limit mid-segment
      load_config(1, {$urandom, $urandom}, {$urandom, $urandom}, '0, START_W'(1), '0,
                  {$urandom, $urandom});
      repeat (4) send_byte(8'($urandom), 1'b0);
      settle();
      write_reg(CSR_MAX_MATCHES, 64'd2);
      send_byte(8'($urandom), 1'b1);
      settle();

      // random phases, each with fresh settings and idling mix
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         random_config();
         case ($urandom_range(0, 3))
            0: begin
               send_gap_max = 0;
               recv_gap_max = 0;
            end
            1: begin
               send_gap_max = 0;
               recv_gap_max = 16;
            end
            2: begin
               send_gap_max = 16;
               recv_gap_max = 0;
            end
            default: begin
               send_gap_max = 16;
               recv_gap_max = 16;
            end
         endcase
         // stall the output for a long stretch while bytes keep coming
         if (phase == 2) begin
            send_gap_max = 0;
            hold_request = 1'b1;
         end
         repeat ($urandom_range(3, 8)) send_segment();
         settle();
         phase++;
      end

      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/wbps_pkg.sv
sv/wbps_front.sv
sv/wbps_queue.sv
sv/wbps_back.sv
sv/wildcard_byte_pattern_scanner.sv
dv/testbench.sv
